FILE: rtl/tlpq_pkg.sv
package tlpq_pkg;

   // Default number of entries in the store.
   localparam int CAPACITY_DEF = 16;

   // Number of valid priority levels; a requested level at or above this is refused.
   localparam int LEVELS = 3;

   localparam int ID_W    = 32;
   localparam int LEVEL_W = 2;
   localparam int STAMP_W = 48;
   localparam int FUNC_W  = 2;
   localparam int STS_W   = 3;

   // Operation codes carried by req_func.
   localparam logic [FUNC_W-1:0] FN_REGISTER = 2'd0;
   localparam logic [FUNC_W-1:0] FN_SET_PRIO = 2'd1;
   localparam logic [FUNC_W-1:0] FN_TAKE     = 2'd2;
   localparam logic [FUNC_W-1:0] FN_FIND     = 2'd3;

   // Result status codes carried by rsp_status.
   localparam logic [STS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STS_W-1:0] STS_NOT_FOUND = 3'd1;
   localparam logic [STS_W-1:0] STS_BAD_LEVEL = 3'd2;
   localparam logic [STS_W-1:0] STS_EMPTY     = 3'd3;
   localparam logic [STS_W-1:0] STS_FULL      = 3'd4;

   // Level given to a newly registered entry.
   localparam logic [LEVEL_W-1:0] LVL_LOW = 2'd0;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [LEVEL_W-1:0] level;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/tlpq_ctrl.sv
module tlpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tlpq_pkg::dp_status_type sts,
   output tlpq_pkg::ctl_cmd_type  cmd
);

   tlpq_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpq_pkg::ST_IDLE: begin
            if (req_valid) state_in = tlpq_pkg::ST_SCAN;
         end
         tlpq_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = tlpq_pkg::ST_DRAIN;
         end
         tlpq_pkg::ST_DRAIN: begin
            state_in = tlpq_pkg::ST_COMMIT;
         end
         tlpq_pkg::ST_COMMIT: begin
            if (sts.out_free) state_in = tlpq_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlpq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tlpq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         tlpq_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         tlpq_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         tlpq_pkg::ST_COMMIT: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: rtl/tlpq_dp.sv
module tlpq_dp #(
   parameter int CAPACITY = tlpq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tlpq_pkg::ctl_cmd_type                cmd,
   output tlpq_pkg::dp_status_type              sts,
   input  logic [tlpq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tlpq_pkg::ID_W-1:0]     req_ticket_id,
   input  logic [tlpq_pkg::LEVEL_W-1:0]         req_new_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tlpq_pkg::STS_W-1:0]           rsp_status,
   output logic signed [tlpq_pkg::ID_W-1:0]     rsp_out_id,
   output logic [tlpq_pkg::LEVEL_W-1:0]         rsp_out_level,
   output logic [tlpq_pkg::STAMP_W-1:0]         rsp_out_stamp
);

   localparam int IW = $clog2(CAPACITY);

   // Latched request.
   logic [tlpq_pkg::FUNC_W-1:0]  func_ff;
   logic [tlpq_pkg::ID_W-1:0]    id_ff;
   logic [tlpq_pkg::LEVEL_W-1:0] lvl_ff;

   // Entry store: valid bits in flops, payload in a memory.
   logic [CAPACITY-1:0]  valid_ff, valid_in;
   tlpq_pkg::entry_type  mem [CAPACITY];
   logic                 mem_we;
   tlpq_pkg::entry_type  mem_wdata;

   // Scan pipeline.
   logic [IW-1:0]        addr_ff;
   logic [IW-1:0]        rd_idx_ff;
   logic                 rd_vld_ff;
   tlpq_pkg::entry_type  rd_entry_ff;

   // Best candidate so far.
   logic                 found_ff;
   logic [IW-1:0]        best_idx_ff;
   tlpq_pkg::entry_type  best_ff;

   logic [tlpq_pkg::STAMP_W-1:0] arrival_ff, arrival_in;

   // Result register.
   logic                          rsp_valid_ff;
   logic [tlpq_pkg::STS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [tlpq_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [tlpq_pkg::LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic [tlpq_pkg::STAMP_W-1:0]  rsp_stamp_ff, rsp_stamp_in;

   logic entry_live, id_hit, cand, high_first, better, take;

   assign sts.scan_last = (addr_ff == IW'(CAPACITY - 1));
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // Candidate evaluation for the entry that came back from the memory.
   always_comb begin
      entry_live = valid_ff[rd_idx_ff];
      id_hit     = (rd_entry_ff.id == id_ff);
      high_first = (func_ff != tlpq_pkg::FN_SET_PRIO);
      case (func_ff)
         tlpq_pkg::FN_REGISTER: cand = !entry_live;
         tlpq_pkg::FN_TAKE:     cand = entry_live;
         default:               cand = entry_live && id_hit;
      endcase
      if (!found_ff) begin
         better = 1'b1;
      end else if (func_ff == tlpq_pkg::FN_REGISTER) begin
         better = 1'b0;
      end else if (rd_entry_ff.level != best_ff.level) begin
         better = high_first ? (rd_entry_ff.level > best_ff.level)
                             : (rd_entry_ff.level < best_ff.level);
      end else begin
         better = (rd_entry_ff.stamp < best_ff.stamp);
      end
      take = rd_vld_ff && cand && better;
   end

   // Commit decision and result formation.
   always_comb begin
      valid_in      = valid_ff;
      arrival_in    = arrival_ff;
      mem_we        = 1'b0;
      mem_wdata     = best_ff;
      rsp_status_in = tlpq_pkg::STS_OK;
      rsp_id_in     = id_ff;
      rsp_level_in  = '0;
      rsp_stamp_in  = '0;
      case (func_ff)
         tlpq_pkg::FN_REGISTER: begin
            if (found_ff) begin
               mem_we                = cmd.commit;
               mem_wdata.id          = id_ff;
               mem_wdata.level       = tlpq_pkg::LVL_LOW;
               mem_wdata.stamp       = arrival_ff;
               valid_in[best_idx_ff] = 1'b1;
               arrival_in            = arrival_ff + tlpq_pkg::STAMP_W'(1);
               rsp_level_in          = tlpq_pkg::LVL_LOW;
               rsp_stamp_in          = arrival_ff;
            end else begin
               rsp_status_in = tlpq_pkg::STS_FULL;
            end
         end
         tlpq_pkg::FN_SET_PRIO: begin
            if (int'(lvl_ff) >= tlpq_pkg::LEVELS) begin
               rsp_status_in = tlpq_pkg::STS_BAD_LEVEL;
            end else if (!found_ff) begin
               rsp_status_in = tlpq_pkg::STS_NOT_FOUND;
            end else begin
               mem_we          = cmd.commit;
               mem_wdata.level = lvl_ff;
               rsp_level_in    = lvl_ff;
               rsp_stamp_in    = best_ff.stamp;
            end
         end
         tlpq_pkg::FN_TAKE: begin
            if (found_ff) begin
               valid_in[best_idx_ff] = 1'b0;
               rsp_id_in             = best_ff.id;
               rsp_level_in          = best_ff.level;
               rsp_stamp_in          = best_ff.stamp;
            end else begin
               rsp_status_in = tlpq_pkg::STS_EMPTY;
               rsp_id_in     = '0;
            end
         end
         tlpq_pkg::FN_FIND: begin
            if (found_ff) begin
               rsp_id_in    = best_ff.id;
               rsp_level_in = best_ff.level;
               rsp_stamp_in = best_ff.stamp;
            end else begin
               rsp_status_in = tlpq_pkg::STS_NOT_FOUND;
            end
         end
         default: begin
            rsp_status_in = tlpq_pkg::STS_NOT_FOUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[best_idx_ff] <= mem_wdata;
      rd_entry_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         func_ff <= req_func;
         id_ff   <= $unsigned(req_ticket_id);
         lvl_ff  <= req_new_level;
      end
      rd_idx_ff <= addr_ff;
      if (take) begin
         best_idx_ff <= rd_idx_ff;
         best_ff     <= rd_entry_ff;
      end
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_stamp_ff  <= rsp_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         arrival_ff   <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (cmd.start) begin
            addr_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan) addr_ff <= addr_ff + IW'(1);
            if (take) found_ff <= 1'b1;
         end
         if (cmd.commit) begin
            valid_ff     <= valid_in;
            arrival_ff   <= arrival_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_id    = $signed(rsp_id_ff);
   assign rsp_out_level = rsp_level_ff;
   assign rsp_out_stamp = rsp_stamp_ff;

endmodule

FILE: rtl/three_level_priority_queue_by_id_top.sv
// Priority queue of tickets keyed by identifier, holding up to CAPACITY entries of
// identifier, level (0 to 2) and a 48-bit arrival stamp. Each request (register, set
// priority, take next, find) is answered by exactly one result. Every request is
// served by one pass over the entry memory through its single read port, one entry
// per clock, after which the result is loaded into the output register and the
// controller returns to idle, where the next request can be accepted; only one
// request is in progress at a time. The load waits for as long as an earlier result
// is still stalled in the output register. A new request is accepted as soon as
// the previous one has been committed, even while its result still waits for the
// consumer.

module three_level_priority_queue_by_id_top #(
   parameter int CAPACITY = tlpq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tlpq_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tlpq_pkg::ID_W-1:0]     req_ticket_id,
   input  logic [tlpq_pkg::LEVEL_W-1:0]         req_new_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tlpq_pkg::STS_W-1:0]           rsp_status,
   output logic signed [tlpq_pkg::ID_W-1:0]     rsp_out_id,
   output logic [tlpq_pkg::LEVEL_W-1:0]         rsp_out_level,
   output logic [tlpq_pkg::STAMP_W-1:0]         rsp_out_stamp
);

   // The controller steps each request through accept, scan, drain and commit.
   // The scan walks every slot in order; the drain cycle evaluates the last slot
   // read, since the memory read data arrives in the cycle after its address.
   tlpq_pkg::ctl_cmd_type   cmd;
   tlpq_pkg::dp_status_type sts;

   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the entries, the arrival counter, the best-candidate
   // registers of the scan and the result register. Ties on level are broken by
   // the smaller stamp and then by the lower slot, because a later slot only
   // replaces the best one when it is strictly better.
   tlpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_ticket_id (req_ticket_id),
      .req_new_level (req_new_level),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_level (rsp_out_level),
      .rsp_out_stamp (rsp_out_stamp)
   );

endmodule

FILE: rtl/tlpq_chk.sv
module tlpq_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [tlpq_pkg::STS_W-1:0]          rsp_status,
   input logic signed [tlpq_pkg::ID_W-1:0]    rsp_out_id,
   input logic [tlpq_pkg::LEVEL_W-1:0]        rsp_out_level,
   input logic [tlpq_pkg::STAMP_W-1:0]        rsp_out_stamp
);

   // No result is shown right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_out_id)
         && $stable(rsp_out_level) && $stable(rsp_out_stamp))
      else $error("stalled result changed");

   // One request at a time: an accepted request makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while a scan was due");

   // Refused requests report level and stamp as zero.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tlpq_pkg::STS_OK |-> rsp_out_level == '0
         && rsp_out_stamp == '0)
      else $error("refused request carries level or stamp");

   // A successful result always names a level in range.
   a_ok_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == tlpq_pkg::STS_OK |-> int'(rsp_out_level) < tlpq_pkg::LEVELS)
      else $error("result level out of range");

endmodule

bind three_level_priority_queue_by_id_top tlpq_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_out_id    (rsp_out_id),
   .rsp_out_level (rsp_out_level),
   .rsp_out_stamp (rsp_out_stamp)
);
